/* design/keyframe_record_packer_assert.svh */
// Assertion macros used by the keyframe record packer checker.
`ifndef KEYFRAME_RECORD_PACKER_ASSERT_SVH
`define KEYFRAME_RECORD_PACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define KRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyframe packer: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define KRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyframe packer: next-cycle check failed");

`endif

/* design/kfrp_pkg.sv */
// Types and constants of the keyframe record packer.
`default_nettype none

package kfrp_pkg;

  localparam int FIELD_W    = 32;
  localparam int BYTE_W     = 8;
  localparam int DIGIT_W    = 7;
  localparam int VALUE_BYTES = FIELD_W / BYTE_W;
  localparam int BCNT_W     = $clog2(VALUE_BYTES);

  localparam logic [BYTE_W-1:0] KEY_FRAME  = 8'd67;
  localparam logic [BYTE_W-1:0] KEY_VALUE  = 8'd68;
  localparam logic [BYTE_W-1:0] KEY_INTERP = 8'd69;

  typedef struct packed {
    logic [FIELD_W-1:0] frame_number;
    logic [FIELD_W-1:0] value_bits;
    logic [FIELD_W-1:0] interpolator_id;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              record_end;
  } out_t;

  // Control of one shift register: parallel load or one digit shift.
  typedef struct packed {
    logic load;
    logic shift;
  } sr_ctl_t;

endpackage

`default_nettype wire

/* design/kfrp_varint_sr.sv */
// Varint shift register: emits a 32-bit value seven bits per shift.
`default_nettype none

module kfrp_varint_sr (
  input  wire logic                         clk,
  input  wire kfrp_pkg::sr_ctl_t            ctl,
  input  wire logic [kfrp_pkg::FIELD_W-1:0] load_val,
  output logic      [kfrp_pkg::DIGIT_W-1:0] digit,
  output logic                              more,
  output logic                              nonzero
);

  logic [kfrp_pkg::FIELD_W-1:0] val_r;
  logic [kfrp_pkg::FIELD_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.load) begin
      val_nxt = load_val;
    end else if (ctl.shift) begin
      val_nxt = val_r >> kfrp_pkg::DIGIT_W;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign digit   = val_r[kfrp_pkg::DIGIT_W-1:0];
  // more bytes follow while anything is left above the current digit
  assign more    = |val_r[kfrp_pkg::FIELD_W-1:kfrp_pkg::DIGIT_W];
  assign nonzero = |val_r;

endmodule

`default_nettype wire

/* design/kfrp_byte_sr.sv */
// Byte shift register: emits a 32-bit word lowest byte first.
`default_nettype none

module kfrp_byte_sr (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire kfrp_pkg::sr_ctl_t            ctl,
  input  wire logic [kfrp_pkg::FIELD_W-1:0] load_val,
  output logic      [kfrp_pkg::BYTE_W-1:0]  byte_out,
  output logic                              last
);

  logic [kfrp_pkg::FIELD_W-1:0] val_r;
  logic [kfrp_pkg::FIELD_W-1:0] val_nxt;
  logic [kfrp_pkg::BCNT_W-1:0]  cnt_r;
  logic [kfrp_pkg::BCNT_W-1:0]  cnt_nxt;

  always_comb begin
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      val_nxt = load_val;
      cnt_nxt = '0;
    end else if (ctl.shift) begin
      val_nxt = val_r >> kfrp_pkg::BYTE_W;
      cnt_nxt = cnt_r + kfrp_pkg::BCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign byte_out = val_r[kfrp_pkg::BYTE_W-1:0];
  assign last     = (cnt_r == kfrp_pkg::BCNT_W'(kfrp_pkg::VALUE_BYTES - 1));

endmodule

`default_nettype wire

/* design/keyframe_record_packer.sv */
// Keyframe record packer: one keyframe in, a 7 to 17 byte record out.
// The first byte is produced from state S_KEYF into the output register after the
// keyframe is accepted. Throughput: one byte per cycle while out_ready does not stall
// the output, set by the byte sequencer and its single output register.
// A new keyframe is taken only while the sequencer is idle.
// Reset (rst_n low, synchronous) idles the sequencer and empties the output.
`default_nettype none

module keyframe_record_packer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire kfrp_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output kfrp_pkg::out_t     out_data
);

  // Sequencer: one state per section of the record.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_KEYF   = 7'b0000010,
    S_FRAME  = 7'b0000100,
    S_KEYV   = 7'b0001000,
    S_VAL    = 7'b0010000,
    S_KEYI   = 7'b0100000,
    S_INTERP = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic           out_valid_r, out_valid_nxt;
  kfrp_pkg::out_t out_data_r, out_data_nxt;

  logic in_fire;
  logic step;      // a byte is produced into the output register this cycle

  kfrp_pkg::sr_ctl_t frame_ctl, val_ctl, interp_ctl;

  logic [kfrp_pkg::DIGIT_W-1:0] frame_digit, interp_digit;
  logic                         frame_more, interp_more, interp_nz;
  logic                         frame_nz_unused;
  logic [kfrp_pkg::BYTE_W-1:0]  val_byte;
  logic                         val_last;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign step     = (state_r != S_IDLE) && (!out_valid_r || out_ready);

  // Digit shifters for the two varints and the raw value word.
  kfrp_varint_sr u_frame_sr (
    .clk      (clk),
    .ctl      (frame_ctl),
    .load_val (in_data.frame_number),
    .digit    (frame_digit),
    .more     (frame_more),
    .nonzero  (frame_nz_unused)
  );

  kfrp_byte_sr u_val_sr (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (val_ctl),
    .load_val (in_data.value_bits),
    .byte_out (val_byte),
    .last     (val_last)
  );

  kfrp_varint_sr u_interp_sr (
    .clk      (clk),
    .ctl      (interp_ctl),
    .load_val (in_data.interpolator_id),
    .digit    (interp_digit),
    .more     (interp_more),
    .nonzero  (interp_nz)
  );

  always_comb begin
    state_nxt        = state_r;
    out_data_nxt     = out_data_r;
    frame_ctl.load   = in_fire;
    frame_ctl.shift  = 1'b0;
    val_ctl.load     = in_fire;
    val_ctl.shift    = 1'b0;
    interp_ctl.load  = in_fire;
    interp_ctl.shift = 1'b0;

    if (step) begin
      out_data_nxt.record_end = 1'b0;
      case (state_r)
        S_KEYF: begin
          out_data_nxt.out_byte = kfrp_pkg::KEY_FRAME;
          state_nxt             = S_FRAME;
        end
        S_FRAME: begin
          out_data_nxt.out_byte = {frame_more, frame_digit};
          frame_ctl.shift       = 1'b1;
          if (!frame_more) begin
            state_nxt = S_KEYV;
          end
        end
        S_KEYV: begin
          out_data_nxt.out_byte = kfrp_pkg::KEY_VALUE;
          state_nxt             = S_VAL;
        end
        S_VAL: begin
          out_data_nxt.out_byte = val_byte;
          val_ctl.shift         = 1'b1;
          if (val_last) begin
            // zero id: the interpolator section is dropped
            if (interp_nz) begin
              state_nxt = S_KEYI;
            end else begin
              state_nxt               = S_IDLE;
              out_data_nxt.record_end = 1'b1;
            end
          end
        end
        S_KEYI: begin
          out_data_nxt.out_byte = kfrp_pkg::KEY_INTERP;
          state_nxt             = S_INTERP;
        end
        S_INTERP: begin
          out_data_nxt.out_byte = {interp_more, interp_digit};
          interp_ctl.shift      = 1'b1;
          if (!interp_more) begin
            state_nxt               = S_IDLE;
            out_data_nxt.record_end = 1'b1;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end else if (in_fire) begin
      state_nxt = S_KEYF;
    end
  end

  // Output register: filled on step, emptied when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* design/kfrp_check.sv */
// Port-level checker for the keyframe record packer, with its bind.
`default_nettype none
`include "keyframe_record_packer_assert.svh"

module kfrp_check (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire kfrp_pkg::out_t out_data
);

  logic in_beat;

  assign in_beat = in_valid && in_ready;

  // a keyframe occupies the sequencer: no second beat right behind it
  `KRP_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_beat, !in_ready)

  // a stalled result beat holds
  `KRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // a mid-record byte waiting means the record is not finished
  `KRP_ASSERT_IMPL(a_mid_record_busy, clk, rst_n, out_valid && !out_data.record_end, !in_ready)

  // ready while idle implies the output is empty or holds a record end
  `KRP_ASSERT_IMPL(a_idle_out, clk, rst_n, in_ready, !out_valid || out_data.record_end)

endmodule

bind keyframe_record_packer kfrp_check u_kfrp_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
